@@ design/scti_pkg.sv @@
// Shared types, codes and helpers for the sorted curve table interpolator.
// No dependencies; every other design file imports this package.
package scti_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_W        = 16;
    localparam int INDEX_W        = 6;
    localparam int TOTAL_W        = 7;
    localparam int MODE_W         = 3;
    localparam int STATUS_W       = 2;
    localparam int PROD_W         = 2 * (COORD_W + 1);
    localparam int DIST_W         = COORD_W + 1;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [MODE_W-1:0] {
        OP_ADD     = 3'd0,
        OP_REMOVE  = 3'd1,
        OP_EDIT    = 3'd2,
        OP_READ    = 3'd3,
        OP_LOOKUP  = 3'd4,
        OP_RECLAMP = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_IDX  = 2'd1,
        ST_FULL     = 2'd2,
        ST_NO_COVER = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_BOX_MIN_X = 2'd0,
        REG_BOX_MIN_Y = 2'd1,
        REG_BOX_MAX_X = 2'd2,
        REG_BOX_MAX_Y = 2'd3
    } cfg_reg_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INS_START,
        S_INS_RD,
        S_INS_CHK,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_RD_ADDR,
        S_RD_DATA,
        S_LU_RD,
        S_LU_CHK,
        S_LU_MUL,
        S_LU_DST,
        S_LU_DIV,
        S_LU_FIN,
        S_CL_RD,
        S_CL_WR,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic start;
        logic [PROD_W-1:0] num;
        logic [DIST_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic [PROD_W-1:0] quo;
    } div_rsp_t;

    function automatic coord_t clamp_coord(coord_t v, coord_t lo, coord_t hi);
        coord_t r;
        r = v;
        if (r < lo) r = lo;
        if (r > hi) r = hi;
        return r;
    endfunction

endpackage

@@ design/sorted_curve_table_interpolator_top.sv @@
// Top level of the sorted curve table interpolator: stream ports and hierarchy.
// Depends on scti_pkg, scti_mem, scti_div and scti_ctrl.
//
// Channel   Direction  Beat contents
// s_*       in         tuser: mode; tdata: index, in_x, in_y
// m_*       out        tuser: status; tdata: out_index, out_x, out_y, point_total
// cfg_*     in         box register write, index 0..3, no read-back
//
// A refused item goes straight to the result; an edit at the front of a full table is a delete
// walk, then an insert walk; the memory walk sets its time (one read port, so each entry visited
// takes a read state and a check or write state), and a lookup adds the bit-serial divide.
// Reset empties the table at once; no clearing pass is needed.
// A finished result waits in the output register while the next beat is accepted;
// the sequencer stalls only when a second result is ready before the first is taken.
module sorted_curve_table_interpolator_top import scti_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [COORD_W-1:0]   cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,   // index[5:0], in_x[21:6], in_y[37:22], zero[39:38]
    input  logic [MODE_W-1:0]    s_tuser,   // mode[2:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata,   // out_index[5:0], out_x[21:6], out_y[37:22],
                                            // point_total[44:38], zero[47:45]
    output logic [STATUS_W-1:0]  m_tuser    // status[1:0]
);

    localparam int AW = $clog2(MAX_POINTS);

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [2*COORD_W-1:0] mem_wdata, mem_rdata;
    div_req_t             div_req;
    div_rsp_t             div_rsp;
    logic [INDEX_W-1:0]   out_index;
    coord_t               out_x, out_y;
    logic [TOTAL_W-1:0]   out_total;

    scti_mem #(.DEPTH(MAX_POINTS)) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    scti_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    scti_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_mode    (s_tuser),
        .in_index   (s_tdata[5:0]),
        .in_x       (coord_t'(s_tdata[21:6])),
        .in_y       (coord_t'(s_tdata[37:22])),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_index  (out_index),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_total  (out_total),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata),
        .div_req    (div_req),
        .div_rsp    (div_rsp)
    );

    assign m_tdata = {3'b000, out_total, out_y, out_x, out_index};

endmodule

@@ design/scti_mem.sv @@
// Point memory: one write port and one read port with registered read data.
// Depends on scti_pkg for the coordinate width.
module scti_mem import scti_pkg::*; #(
    parameter int DEPTH = MAX_POINTS_DEF
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [2*COORD_W-1:0]       wdata,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [2*COORD_W-1:0]       rdata
);

    logic [2*COORD_W-1:0] mem_array [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_array[waddr] <= wdata;
        end
        rdata <= mem_array[raddr];
    end

endmodule

@@ design/scti_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on scti_pkg for the request and response structs.
module scti_div import scti_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [DIST_W-1:0] rem_reg, rem_next;
    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [DIST_W-1:0] den_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIST_W:0]   trial;

    always_comb begin
        trial = {rem_reg, quo_reg[PROD_W-1]};
        if (trial >= {1'b0, den_reg}) begin
            rem_next = DIST_W'(trial - {1'b0, den_reg});
            quo_next = {quo_reg[PROD_W-2:0], 1'b1};
        end else begin
            rem_next = trial[DIST_W-1:0];
            quo_next = {quo_reg[PROD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(PROD_W);
            rem_reg  <= '0;
            quo_reg  <= req.num;
            den_reg  <= req.den;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

@@ design/scti_ctrl.sv @@
// Operation sequencer: walks the point memory, holds the clamp box and the result register.
// Depends on scti_pkg; drives scti_mem and scti_div.
module scti_ctrl import scti_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [COORD_W-1:0]                cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [MODE_W-1:0]                 in_mode,
    input  logic [INDEX_W-1:0]                in_index,
    input  coord_t                            in_x,
    input  coord_t                            in_y,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [STATUS_W-1:0]               out_status,
    output logic [INDEX_W-1:0]                out_index,
    output coord_t                            out_x,
    output coord_t                            out_y,
    output logic [TOTAL_W-1:0]                out_total,
    output logic                              mem_we,
    output logic [$clog2(MAX_POINTS)-1:0]     mem_waddr,
    output logic [2*COORD_W-1:0]              mem_wdata,
    output logic [$clog2(MAX_POINTS)-1:0]     mem_raddr,
    input  logic [2*COORD_W-1:0]              mem_rdata,
    output div_req_t                          div_req,
    input  div_rsp_t                          div_rsp
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    seq_state_t state_reg, state_next;

    coord_t box_min_x_reg, box_min_y_reg, box_max_x_reg, box_max_y_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  ptr_reg;
    logic [AW-1:0]  pos_reg;
    op_t            mode_reg;
    coord_t         ix_reg, cx_reg, cy_reg;
    coord_t         prev_x_reg, prev_y_reg;
    logic signed [DIST_W-1:0] dx_reg, dy_reg;
    logic [DIST_W-1:0]        dist_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic           neg_reg;

    status_t        res_status_reg;
    logic [INDEX_W-1:0] res_index_reg;
    coord_t         res_x_reg, res_y_reg;

    logic           m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [INDEX_W-1:0]  m_index_reg;
    coord_t         m_x_reg, m_y_reg;
    logic [TOTAL_W-1:0]  m_total_reg;

    coord_t         rd_x, rd_y;
    logic           accept;
    logic           bad_index;
    logic           full;
    logic           last_ptr;
    logic           seg_hit;
    logic           load_out;
    logic [AW-1:0]  ptr_addr, ptr_addr_inc;
    logic signed [DIST_W-1:0] quo_signed;

    assign rd_x         = coord_t'(mem_rdata[2*COORD_W-1:COORD_W]);
    assign rd_y         = coord_t'(mem_rdata[COORD_W-1:0]);
    assign accept       = in_valid && in_ready;
    assign in_ready     = (state_reg == S_IDLE);
    assign bad_index    = 32'(in_index) >= 32'(count_reg);
    assign full         = (count_reg == CW'(MAX_POINTS));
    assign last_ptr     = (CW'(ptr_reg + 1'b1) == count_reg);
    assign ptr_addr     = ptr_reg[AW-1:0];
    assign ptr_addr_inc = AW'(ptr_reg + 1'b1);
    assign seg_hit      = (prev_x_reg <= ix_reg) && (rd_x >= ix_reg) && (rd_x > prev_x_reg);
    assign load_out     = (state_reg == S_DONE) && (!m_valid_reg || out_ready);
    assign quo_signed   = neg_reg ? -$signed(div_rsp.quo[DIST_W-1:0])
                                  : $signed(div_rsp.quo[DIST_W-1:0]);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    priority case (in_mode)
                        OP_ADD:               state_next = full ? S_DONE : S_INS_START;
                        OP_REMOVE, OP_EDIT:   state_next = bad_index ? S_DONE : S_DEL_RD;
                        OP_READ:              state_next = bad_index ? S_DONE : S_RD_ADDR;
                        OP_LOOKUP:            state_next = (count_reg < CW'(2)) ? S_DONE : S_LU_RD;
                        OP_RECLAMP:           state_next = (count_reg == '0) ? S_DONE : S_CL_RD;
                        default:              state_next = S_DONE;
                    endcase
                end
            end
            S_INS_START: state_next = (count_reg == '0) ? S_INS_WR : S_INS_RD;
            S_INS_RD:    state_next = S_INS_CHK;
            S_INS_CHK: begin
                if (rd_x > cx_reg && ptr_reg != '0) begin
                    state_next = S_INS_RD;
                end else begin
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:    state_next = S_DONE;
            S_DEL_RD: begin
                if (last_ptr) begin
                    state_next = (mode_reg == OP_EDIT) ? S_INS_START : S_DONE;
                end else begin
                    state_next = S_DEL_WR;
                end
            end
            S_DEL_WR:    state_next = S_DEL_RD;
            S_RD_ADDR:   state_next = S_RD_DATA;
            S_RD_DATA:   state_next = S_DONE;
            S_LU_RD:     state_next = S_LU_CHK;
            S_LU_CHK: begin
                if (ptr_reg == '0) begin
                    state_next = S_LU_RD;
                end else if (seg_hit) begin
                    state_next = S_LU_MUL;
                end else begin
                    state_next = last_ptr ? S_DONE : S_LU_RD;
                end
            end
            S_LU_MUL:    state_next = S_LU_DST;
            S_LU_DST:    state_next = S_LU_DIV;
            S_LU_DIV:    state_next = div_rsp.done ? S_LU_FIN : S_LU_DIV;
            S_LU_FIN:    state_next = S_DONE;
            S_CL_RD:     state_next = S_CL_WR;
            S_CL_WR:     state_next = last_ptr ? S_DONE : S_CL_RD;
            S_DONE:      state_next = load_out ? S_IDLE : S_DONE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb begin
        mem_we        = 1'b0;
        mem_waddr     = ptr_addr;
        mem_wdata     = mem_rdata;
        mem_raddr     = ptr_addr;
        div_req.start = 1'b0;
        div_req.num   = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        div_req.den   = dist_reg;
        unique case (state_reg)
            S_INS_CHK: begin
                mem_we    = (rd_x > cx_reg);
                mem_waddr = ptr_addr_inc;
            end
            S_INS_WR: begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg;
                mem_wdata = {cx_reg, cy_reg};
            end
            S_DEL_RD: begin
                mem_raddr = ptr_addr_inc;
            end
            S_DEL_WR: begin
                mem_we = 1'b1;
            end
            S_CL_WR: begin
                mem_we    = 1'b1;
                mem_wdata = {clamp_coord(rd_x, box_min_x_reg, box_max_x_reg),
                             clamp_coord(rd_y, box_min_y_reg, box_max_y_reg)};
            end
            S_LU_DST: begin
                div_req.start = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
            box_min_x_reg <= coord_t'(-32768);
            box_min_y_reg <= coord_t'(-32768);
            box_max_x_reg <= coord_t'(32767);
            box_max_y_reg <= coord_t'(32767);
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                unique case (cfg_index)
                    REG_BOX_MIN_X: box_min_x_reg <= coord_t'(cfg_data);
                    REG_BOX_MIN_Y: box_min_y_reg <= coord_t'(cfg_data);
                    REG_BOX_MAX_X: box_max_x_reg <= coord_t'(cfg_data);
                    REG_BOX_MAX_Y: box_max_y_reg <= coord_t'(cfg_data);
                    default: begin
                    end
                endcase
            end

            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (out_ready) begin
                m_valid_reg <= 1'b0;
            end

            if ((state_reg == S_DEL_RD) && last_ptr) begin
                count_reg <= count_reg - 1'b1;
            end else if (state_reg == S_INS_WR) begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg       <= op_t'(in_mode);
            ix_reg         <= in_x;
            cx_reg         <= clamp_coord(in_x, box_min_x_reg, box_max_x_reg);
            cy_reg         <= clamp_coord(in_y, box_min_y_reg, box_max_y_reg);
            res_index_reg  <= '0;
            res_x_reg      <= '0;
            res_y_reg      <= '0;
            priority case (in_mode)
                OP_ADD: begin
                    ptr_reg        <= CW'(in_index);
                    res_status_reg <= full ? ST_FULL : ST_OK;
                end
                OP_REMOVE, OP_EDIT, OP_READ: begin
                    ptr_reg        <= CW'(in_index);
                    res_status_reg <= bad_index ? ST_BAD_IDX : ST_OK;
                end
                OP_LOOKUP: begin
                    ptr_reg        <= '0;
                    res_status_reg <= (count_reg < CW'(2)) ? ST_NO_COVER : ST_OK;
                end
                default: begin
                    ptr_reg        <= '0;
                    res_status_reg <= ST_OK;
                end
            endcase
        end

        unique case (state_reg)
            S_INS_START: begin
                ptr_reg <= CW'(count_reg - 1'b1);
                pos_reg <= '0;
            end
            S_INS_CHK: begin
                if (rd_x > cx_reg) begin
                    pos_reg <= '0;
                    ptr_reg <= CW'(ptr_reg - 1'b1);
                end else begin
                    pos_reg <= ptr_addr_inc;
                end
            end
            S_INS_WR: begin
                res_index_reg <= INDEX_W'(pos_reg);
            end
            S_DEL_WR: begin
                ptr_reg <= CW'(ptr_reg + 1'b1);
            end
            S_RD_DATA: begin
                res_x_reg <= rd_x;
                res_y_reg <= rd_y;
            end
            S_LU_CHK: begin
                dx_reg     <= DIST_W'(ix_reg) - DIST_W'(prev_x_reg);
                dy_reg     <= DIST_W'(rd_y) - DIST_W'(prev_y_reg);
                dist_reg   <= DIST_W'(rd_x) - DIST_W'(prev_x_reg);
                if (ptr_reg == '0 || !seg_hit) begin
                    prev_x_reg <= rd_x;
                    prev_y_reg <= rd_y;
                    ptr_reg    <= CW'(ptr_reg + 1'b1);
                end
                if (ptr_reg != '0 && !seg_hit && last_ptr) begin
                    res_status_reg <= ST_NO_COVER;
                end
            end
            S_LU_MUL: begin
                prod_reg <= dx_reg * dy_reg;
                neg_reg  <= dy_reg[DIST_W-1];
            end
            S_LU_FIN: begin
                res_y_reg <= prev_y_reg + coord_t'(quo_signed[COORD_W-1:0]);
            end
            S_CL_WR: begin
                ptr_reg <= CW'(ptr_reg + 1'b1);
            end
            default: begin
            end
        endcase

        if (load_out) begin
            m_status_reg <= res_status_reg;
            m_index_reg  <= res_index_reg;
            m_x_reg      <= res_x_reg;
            m_y_reg      <= res_y_reg;
            m_total_reg  <= TOTAL_W'(count_reg);
        end
    end

    assign out_valid  = m_valid_reg;
    assign out_status = m_status_reg;
    assign out_index  = m_index_reg;
    assign out_x      = m_x_reg;
    assign out_y      = m_y_reg;
    assign out_total  = m_total_reg;

endmodule
